// ===== rtl/dmh_pkg.sv =====
`timescale 1ns / 1ps

package dmh_pkg;

   // Field widths of the request and response beats
   localparam int OPCODE_W  = 2;
   localparam int KEY_W     = 32;
   localparam int HANDLE_W  = 9;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 10;
   localparam int ARITY_W   = 3;

   localparam int CAPACITY_DEF = 512;

   // Children per node: the register saturates into this range
   localparam logic [ARITY_W-1:0] ARITY_MIN   = 3'd2;
   localparam logic [ARITY_W-1:0] ARITY_MID   = 3'd3;
   localparam logic [ARITY_W-1:0] ARITY_MAX   = 3'd4;
   localparam logic [ARITY_W-1:0] ARITY_RESET = ARITY_MID;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PEEK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [KEY_W-1:0]    entry_key;
      logic [HANDLE_W-1:0] entry_handle;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]    out_key;
      logic [HANDLE_W-1:0] out_handle;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   // One heap slot
   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

endpackage

// ===== rtl/dmh_store.sv =====
`timescale 1ns / 1ps

module dmh_store import dmh_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  entry_type                   wr_data,
   input  logic [$clog2(CAPACITY)-1:0] rd_addr,
   output entry_type                   rd_data
);

   entry_type mem [CAPACITY];
   entry_type rdata_ff;

   // One write port, one read port with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign rd_data = rdata_ff;

endmodule

// ===== rtl/dary_min_heap_top.sv =====
`timescale 1ns / 1ps

// d-ary min-heap priority queue of (key, handle) pairs.
//
// Request channel (req_valid / req_stall / req_payload): one beat is one
// operation: insert, delete minimum or peek minimum. The block works on one
// beat at a time and holds req_stall high from acceptance until the result
// is loaded into the response register; the opcode is kept internally.
// Response channel (rsp_valid / rsp_stall / rsp_payload): one beat per
// request with the removed or peeked entry, a status and the count held
// afterwards. A stalled response holds; the block may take the next request
// meanwhile, but cannot finish that one until the slot frees up.
// Each key read uses the single read port. Insert: index, read and compare
// per parent, plus a root write if it reaches the root. Delete: root read,
// last-entry read, then per node a start step, a read and compare per child
// and a decide step, plus a final write if it ends on a leaf. Peek, or delete
// of the last entry: root read only. Full, empty or unused opcode: straight
// to the response. Reset: synchronous, empties the heap and sets arity to 3;
// memory is not cleared. csr_we / csr_wdata write the arity, saturated to
// 2..4; the user must write it only while idle; the block does not check.

module dary_min_heap_top import dmh_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_payload,
   input  logic               csr_we,
   input  logic [ARITY_W-1:0] csr_wdata
);

   localparam int IDXW  = $clog2(CAPACITY);
   localparam int CNTW  = $clog2(CAPACITY + 1);
   localparam int FIRSTW = IDXW + 2;
   // x / 3 == (x * DIV3_MUL) >> DIV3_SHIFT for every x below 2**IDXW
   localparam int DIV3_SHIFT = (IDXW % 2 == 0) ? IDXW + 1 : IDXW + 2;
   localparam longint DIV3_MUL = ((64'd1 << DIV3_SHIFT) + 64'd1) / 3;
   localparam int PRODW = IDXW + DIV3_SHIFT;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_PAR,
      S_UP_RD,
      S_UP_CMP,
      S_ROOT_RD,
      S_ROOT_GET,
      S_LAST_RD,
      S_LAST_GET,
      S_DN_START,
      S_CH_RD,
      S_CH_CMP,
      S_DN_DEC,
      S_DONE
   } state_type;

   state_type            state_ff;
   logic [CNTW-1:0]      count_ff;
   logic [ARITY_W-1:0]   arity_ff;
   logic [OPCODE_W-1:0]  op_ff;
   logic [IDXW-1:0]      pos_ff;
   logic [IDXW-1:0]      parent_ff;
   logic [IDXW-1:0]      ci_ff;
   logic [IDXW-1:0]      best_idx_ff;
   logic [1:0]           child_ff;
   entry_type            cur_ff;
   entry_type            best_ff;
   logic [KEY_W-1:0]     res_key_ff;
   logic [HANDLE_W-1:0]  res_handle_ff;
   logic [STATUS_W-1:0]  res_status_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 wr_en;
   logic [IDXW-1:0]      wr_addr;
   entry_type            wr_data;
   logic [IDXW-1:0]      rd_addr;
   entry_type            rd_data;

   logic [IDXW-1:0]      up_x;
   logic [PRODW-1:0]     div3_prod;
   logic [IDXW-1:0]      parent_in;
   logic [FIRSTW-1:0]    first_in;
   logic                 more_children;
   logic [ARITY_W-1:0]   csr_arity_in;

   dmh_store #(
      .CAPACITY(CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Parent index of pos: shift for 2 and 4, reciprocal multiply for 3
   assign up_x      = pos_ff - IDXW'(1);
   assign div3_prod = PRODW'(up_x) * PRODW'(DIV3_MUL);

   always_comb begin
      case (arity_ff)
         ARITY_MIN: parent_in = up_x >> 1;
         ARITY_MAX: parent_in = up_x >> 2;
         default:   parent_in = div3_prod[PRODW-1:DIV3_SHIFT];
      endcase
   end

   // First child of pos: pos * arity + 1
   always_comb begin
      case (arity_ff)
         ARITY_MIN: first_in = {1'b0, pos_ff, 1'b0} + FIRSTW'(1);
         ARITY_MAX: first_in = {pos_ff, 2'b00} + FIRSTW'(1);
         default:   first_in = {1'b0, pos_ff, 1'b0} + FIRSTW'(pos_ff) + FIRSTW'(1);
      endcase
   end

   // Another sibling exists when this child is not the last of the node and
   // the next index is still inside the heap
   assign more_children = ((ARITY_W'(child_ff) + ARITY_W'(1)) < arity_ff) &&
                          ((IDXW+1)'(ci_ff) + (IDXW+1)'(1) < (IDXW+1)'(count_ff));

   always_comb begin
      if (csr_wdata < ARITY_MIN) begin
         csr_arity_in = ARITY_MIN;
      end else if (csr_wdata > ARITY_MAX) begin
         csr_arity_in = ARITY_MAX;
      end else begin
         csr_arity_in = csr_wdata;
      end
   end

   // Memory ports: read address per state, writes drop the moving entry or
   // the displaced neighbor into the hole
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = cur_ff;
      rd_addr = '0;
      case (state_ff)
         S_UP_PAR: begin
            wr_en = (pos_ff == '0);
         end
         S_UP_RD: begin
            rd_addr = parent_ff;
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (rd_data.key > cur_ff.key) begin
               wr_data = rd_data;
            end
         end
         S_LAST_RD: begin
            rd_addr = count_ff[IDXW-1:0];
         end
         S_DN_START: begin
            wr_en = (first_in >= FIRSTW'(count_ff));
         end
         S_CH_RD: begin
            rd_addr = ci_ff;
         end
         S_DN_DEC: begin
            wr_en = 1'b1;
            if (cur_ff.key > best_ff.key) begin
               wr_data = best_ff;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         arity_ff     <= ARITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            arity_ff <= csr_arity_in;
         end
         // Drop the response once the receiver takes it, unless a finishing
         // item reloads the slot on the same edge
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  res_key_ff    <= '0;
                  res_handle_ff <= '0;
                  res_status_ff <= ST_OK;
                  op_ff         <= req_payload.opcode;
                  case (req_payload.opcode)
                     OP_INSERT: begin
                        if (count_ff == CNTW'(CAPACITY)) begin
                           res_status_ff <= ST_FULL;
                           state_ff      <= S_DONE;
                        end else begin
                           cur_ff   <= '{key: req_payload.entry_key,
                                         handle: req_payload.entry_handle};
                           pos_ff   <= count_ff[IDXW-1:0];
                           count_ff <= count_ff + CNTW'(1);
                           state_ff <= S_UP_PAR;
                        end
                     end
                     OP_DELETE, OP_PEEK: begin
                        if (count_ff == '0) begin
                           res_status_ff <= ST_EMPTY;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_ROOT_RD;
                        end
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_UP_PAR: begin
               if (pos_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  parent_ff <= parent_in;
                  state_ff  <= S_UP_RD;
               end
            end
            S_UP_RD: begin
               state_ff <= S_UP_CMP;
            end
            S_UP_CMP: begin
               // Parent strictly greater: it moves down, keep climbing
               if (rd_data.key > cur_ff.key) begin
                  pos_ff   <= parent_ff;
                  state_ff <= S_UP_PAR;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_ROOT_RD: begin
               state_ff <= S_ROOT_GET;
            end
            S_ROOT_GET: begin
               res_key_ff    <= rd_data.key;
               res_handle_ff <= rd_data.handle;
               if (op_ff == OP_PEEK) begin
                  state_ff <= S_DONE;
               end else begin
                  count_ff <= count_ff - CNTW'(1);
                  if (count_ff == CNTW'(1)) begin
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_LAST_RD;
                  end
               end
            end
            S_LAST_RD: begin
               state_ff <= S_LAST_GET;
            end
            S_LAST_GET: begin
               cur_ff   <= rd_data;
               pos_ff   <= '0;
               state_ff <= S_DN_START;
            end
            S_DN_START: begin
               if (first_in >= FIRSTW'(count_ff)) begin
                  state_ff <= S_DONE;
               end else begin
                  ci_ff    <= first_in[IDXW-1:0];
                  child_ff <= '0;
                  state_ff <= S_CH_RD;
               end
            end
            S_CH_RD: begin
               state_ff <= S_CH_CMP;
            end
            S_CH_CMP: begin
               // Leftmost strictly smallest child wins
               if (child_ff == '0 || rd_data.key < best_ff.key) begin
                  best_ff     <= rd_data;
                  best_idx_ff <= ci_ff;
               end
               if (more_children) begin
                  child_ff <= child_ff + 2'd1;
                  ci_ff    <= ci_ff + IDXW'(1);
                  state_ff <= S_CH_RD;
               end else begin
                  state_ff <= S_DN_DEC;
               end
            end
            S_DN_DEC: begin
               if (cur_ff.key > best_ff.key) begin
                  pos_ff   <= best_idx_ff;
                  state_ff <= S_DN_START;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // Advance only when the response slot is free or being emptied
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff       <= '{out_key: res_key_ff,
                                    out_handle: res_handle_ff,
                                    status: res_status_ff,
                                    entry_count: COUNT_W'(count_ff)};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Busy from the accepting edge until the response is loaded; the opcode
   // is held in op_ff, so the request port is free after acceptance.
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(CAPACITY))
      else $error("entry count above capacity");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken without going busy");

   a_hole_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP_CMP || state_ff == S_DN_START || state_ff == S_DN_DEC)
      |-> (CNTW'(pos_ff) < count_ff))
      else $error("sift position outside the heap");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && !(rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("finished item produced no response");

endmodule

// ===== verif/tb_dary_min_heap_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the d-ary min-heap. A software copy of the heap
// predicts every reply beat as each request beat is taken; replies are
// checked in order against that copy.
module tb_dary_min_heap_top;
   import dmh_pkg::*;

   localparam int CAP           = CAPACITY_DEF;
   localparam int SETTLE_CYCLES = 64;    // pad past the deepest delete
   localparam int HOLD_CYCLES   = 300;   // long reply hold-off
   localparam int STALL_LIMIT   = 2000;  // cycles with no beat before giving up
   localparam int SWEEP_OPS     = 45;    // random beats per arity setting
   localparam int PRINT_LIMIT   = 20;

   // Opcode the block must treat as a no-op
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef enum logic [1:0] {RX_READY, RX_RANDOM, RX_PERIODIC} rx_mode_type;

   // DUT inputs: all known from time zero
   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   req_type            req_payload = '0;
   logic               rsp_stall   = 1'b0;
   logic               csr_we      = 1'b0;
   logic [ARITY_W-1:0] csr_wdata   = ARITY_RESET;

   logic               req_stall;
   logic               rsp_valid;
   rsp_type            rsp_payload;

   // Software heap: slots, fill level and the arity register
   entry_type          heap_mem [CAP];
   int unsigned        heap_fill = 0;
   logic [ARITY_W-1:0] arity_cfg = ARITY_RESET;

   // Replies owed by the block, oldest first
   rsp_type            heap_replies [$];
   rsp_type            want;

   int mismatches  = 0;
   int n_insert    = 0;
   int n_delete    = 0;
   int n_peek      = 0;
   int n_unused    = 0;
   int n_full      = 0;
   int n_empty     = 0;
   int burst_left  = 0;
   int quiet_cycles = 0;

   bit          hold_rsp = 1'b0;
   rx_mode_type rx_mode  = RX_READY;
   int          rx_left  = 0;
   logic [3:0]  rx_phase = '0;

   dary_min_heap_top #(
      .CAPACITY(CAP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Heap prediction
   // ------------------------------------------------------------------

   function automatic void swap_slots(input int unsigned a, input int unsigned b);
      entry_type tmp;
      tmp         = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = tmp;
   endfunction

   // Apply one operation to the software heap and return the reply it owes.
   function automatic rsp_type apply_heap_op(input req_type beat);
      rsp_type     reply;
      int unsigned d, pos, par, first, best, c, last;
      bit          done;
      // Saturate the register into 2..4 children per node
      if (arity_cfg < ARITY_MIN)
         d = ARITY_MIN;
      else if (arity_cfg > ARITY_MAX)
         d = ARITY_MAX;
      else
         d = arity_cfg;
      reply = '0;
      done  = 1'b0;
      case (beat.opcode)
         OP_INSERT: begin
            if (heap_fill >= CAP) begin
               reply.status = ST_FULL;
            end else begin
               pos           = heap_fill;
               heap_mem[pos] = {beat.entry_key, beat.entry_handle};
               heap_fill++;
               // Climb only while the parent is strictly larger
               while (pos > 0 && !done) begin
                  par = (pos - 1) / d;
                  if (heap_mem[par].key > heap_mem[pos].key) begin
                     swap_slots(par, pos);
                     pos = par;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
         end
         OP_DELETE, OP_PEEK: begin
            if (heap_fill == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               reply.out_key    = heap_mem[0].key;
               reply.out_handle = heap_mem[0].handle;
               if (beat.opcode == OP_DELETE) begin
                  last        = heap_fill - 1;
                  heap_mem[0] = heap_mem[last];
                  heap_fill   = last;
                  pos         = 0;
                  // Sink: leftmost strictly smallest child wins, swap only
                  // when the sinking key is strictly larger
                  while (!done) begin
                     first = pos * d + 1;
                     if (first >= last) begin
                        done = 1'b1;
                     end else begin
                        best = first;
                        for (c = first + 1; c < first + d; c++)
                           if (c < last && heap_mem[c].key < heap_mem[best].key)
                              best = c;
                        if (heap_mem[pos].key > heap_mem[best].key) begin
                           swap_slots(pos, best);
                           pos = best;
                        end else begin
                           done = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         default: ;  // unused opcode: heap untouched, count reported
      endcase
      reply.entry_count = COUNT_W'(heap_fill);
      return reply;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Mix of tie-prone small keys, extremes and full-range keys
   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 3))
         0:       return KEY_W'($urandom_range(0, 15));
         1:       return $urandom_range(0, 1) ? '1 : '0;
         default: return $urandom();
      endcase
   endfunction

   // Offer one request beat and, once taken, log the reply it owes.
   // Bursts of random length with random gaps in between.
   task automatic send_op(input logic [OPCODE_W-1:0] op,
                          input logic [KEY_W-1:0]    key,
                          input logic [HANDLE_W-1:0] hdl);
      req_type beat;
      rsp_type reply;
      int      gap;
      beat.opcode       = op;
      beat.entry_key    = key;
      beat.entry_handle = hdl;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= beat;
      // Hold the beat until the block stops stalling
      do @(posedge clock); while (req_stall);
      reply = apply_heap_op(beat);
      heap_replies.push_back(reply);
      case (op)
         OP_INSERT: n_insert++;
         OP_DELETE: n_delete++;
         OP_PEEK:   n_peek++;
         default:   n_unused++;
      endcase
      if (reply.status == ST_FULL)  n_full++;
      if (reply.status == ST_EMPTY) n_empty++;
   endtask

   task automatic send_random(input int ins_pct, input int del_pct);
      int                  r;
      logic [OPCODE_W-1:0] op;
      r = $urandom_range(0, 99);
      if (r < ins_pct)
         op = OP_INSERT;
      else if (r < ins_pct + del_pct)
         op = OP_DELETE;
      else if (r < 97)
         op = OP_PEEK;
      else
         op = OP_UNUSED;
      send_op(op, pick_key(), HANDLE_W'($urandom_range(0, (1 << HANDLE_W) - 1)));
   endtask

   // Drop valid, wait for every owed reply, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (heap_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_arity(input logic [ARITY_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      arity_cfg = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Reply side
   // ------------------------------------------------------------------

   // Switch between no stall, random stall and a periodic stall pattern;
   // hold_rsp forces a stall on top of whatever pattern runs.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(16, 160);
      end else begin
         rx_left--;
      end
      rx_phase <= rx_phase + 4'd1;
      case (rx_mode)
         RX_READY:  rsp_stall <= hold_rsp;
         RX_RANDOM: rsp_stall <= hold_rsp || ($urandom_range(0, 2) == 0);
         default:   rsp_stall <= hold_rsp || (rx_phase[2:0] >= 3'd5);
      endcase
   end

   // Check each taken reply beat against the oldest owed reply
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (heap_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
               $display("%0t: reply beat with nothing owed: key %h handle %h status %0d count %0d",
                        $time, rsp_payload.out_key, rsp_payload.out_handle,
                        rsp_payload.status, rsp_payload.entry_count);
         end else begin
            want = heap_replies.pop_front();
            if (rsp_payload.out_key     !== want.out_key    ||
                rsp_payload.out_handle  !== want.out_handle ||
                rsp_payload.status      !== want.status     ||
                rsp_payload.entry_count !== want.entry_count) begin
               mismatches++;
               if (mismatches <= PRINT_LIMIT) begin
                  $display("%0t: expected key %h handle %h status %0d count %0d",
                           $time, want.out_key, want.out_handle,
                           want.status, want.entry_count);
                  $display("%0t: actual   key %h handle %h status %0d count %0d",
                           $time, rsp_payload.out_key, rsp_payload.out_handle,
                           rsp_payload.status, rsp_payload.entry_count);
               end
            end
         end
      end
   end

   // Give up if no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d replies owed",
                  $time, quiet_cycles, heap_replies.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Empty reads, the unused opcode, key and handle extremes, and equal keys
   // whose handles expose the strict-compare and leftmost-child rules.
   // Runs at the reset arity.
   task automatic test_directed_corners();
      send_op(OP_PEEK,   '1, '1);
      send_op(OP_DELETE, '0, '0);
      send_op(OP_UNUSED, '1, '1);
      send_op(OP_INSERT, 32'hFFFF_FFFF, 9'h1FF);
      send_op(OP_INSERT, 32'd0,         9'h000);
      send_op(OP_INSERT, 32'd5,         9'h155);
      send_op(OP_INSERT, 32'd5,         9'h0AA);
      send_op(OP_INSERT, 32'd5,         9'h001);
      send_op(OP_INSERT, 32'hFFFF_FFFF, 9'h002);
      send_op(OP_INSERT, 32'd5,         9'h100);
      send_op(OP_PEEK,   '0, '0);
      // Unused opcode with a loaded heap: count must not move
      send_op(OP_UNUSED, 32'h5A5A_A5A5, 9'h0F0);
      // Drain past empty
      repeat (7) send_op(OP_DELETE, '0, '0);
      send_op(OP_DELETE, '1, '1);
      send_op(OP_PEEK,   '1, '1);
      wait_idle();
   endtask

   // Walk the arity register through every code, saturating ones included.
   // The heap is carried across settings, so sifts also run on a heap
   // built under another arity.
   task automatic test_arity_settings();
      logic [ARITY_W-1:0] sweep [8];
      sweep = '{3'd7, 3'd0, ARITY_MIN, ARITY_MAX, 3'd1, 3'd5, 3'd6, ARITY_MID};
      foreach (sweep[i]) begin
         set_arity(sweep[i]);
         repeat (SWEEP_OPS) send_random(45, 35);
      end
      wait_idle();
   endtask

   // Hold replies off for a long stretch while requests keep coming, so
   // the block backs up and stalls its request side.
   task automatic test_response_hold();
      wait_idle();
      fork
         begin
            @(posedge clock);
            hold_rsp = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      repeat (40) send_random(60, 25);
      wait_idle();
   endtask

   // Fill to capacity at the narrowest arity (deepest tree), push on a
   // full heap, churn around full, then drain hard.
   task automatic test_full_heap();
      set_arity(ARITY_MIN);
      while (heap_fill < CAP)
         send_op(OP_INSERT, pick_key(), HANDLE_W'($urandom_range(0, (1 << HANDLE_W) - 1)));
      repeat (4)
         send_op(OP_INSERT, pick_key(), HANDLE_W'($urandom_range(0, (1 << HANDLE_W) - 1)));
      send_op(OP_PEEK, '0, '0);
      repeat (120) send_random(55, 35);
      repeat (200) send_random(10, 80);
      wait_idle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_arity_settings();
      test_response_hold();
      test_full_heap();
      wait_idle();

      // Anything still owed counts against the run
      mismatches += heap_replies.size();

      $display("Ran %0d request beats: %0d insert, %0d delete, %0d peek, %0d unused opcode.",
               n_insert + n_delete + n_peek + n_unused, n_insert, n_delete, n_peek, n_unused);
      $display("Arity codes 0..7 swept; %0d full-heap inserts, %0d empty-heap reads, %0d mismatches.",
               n_full, n_empty, mismatches);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/dmh_pkg.sv
rtl/dmh_store.sv
rtl/dary_min_heap_top.sv
verif/tb_dary_min_heap_top.sv
